/* sv/mcf_pkg.sv */
// mcf_pkg: shared types, codes and reset values for the midi choke filter
// no dependencies; used by mcf_decide, midi_choke_filter_top, mcf_checker and tb
package mcf_pkg;

  localparam int DefChannels = 16;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] REG_CHAN_SEL  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TRIG_LOW  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TRIG_HIGH = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CHOKE     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_REL_MODE  = 3'd4;

  localparam logic [4:0] RstChanSel  = 5'd0;
  localparam logic [6:0] RstTrigLow  = 7'd42;
  localparam logic [6:0] RstTrigHigh = 7'd42;
  localparam logic [6:0] RstChoke    = 7'd46;
  localparam logic [1:0] RstRelMode  = 2'd2;

  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;

  localparam logic [1:0] REL_ZERO    = 2'd0;
  localparam logic [1:0] REL_CHOKE   = 2'd1;

  typedef struct packed {
    logic [7:0]  status;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic        three;
    logic [31:0] stamp;
  } msg_t;

  typedef struct packed {
    logic [4:0] chan_sel;
    logic [6:0] trig_low;
    logic [6:0] trig_high;
    logic [6:0] choke;
    logic [1:0] rel_mode;
  } cfg_t;

  typedef struct packed {
    logic       emit_off;
    logic       emit_orig;
    logic       wr_en;
    logic [6:0] wr_vel;
    msg_t       off_msg;
  } dec_t;

endpackage

/* sv/mcf_decide.sv */
// mcf_decide: per-message choke decision, purely combinational
// depends on mcf_pkg
module mcf_decide import mcf_pkg::*; (
  input  msg_t       msg_i,
  input  cfg_t       cfg_i,
  input  logic [6:0] stored_i,
  output dec_t       dec_o
);

  logic [3:0] ch;
  logic [3:0] kind;
  logic [6:0] key;
  logic [6:0] vel;
  logic [3:0] want;
  logic       sel_ok;
  logic       is_note;
  logic       is_on;
  logic       in_range;
  logic [6:0] rel;

  assign ch   = msg_i.status[3:0];
  assign kind = msg_i.status[7:4];
  assign key  = msg_i.data_one[6:0];
  assign vel  = msg_i.data_two[6:0];

  assign want     = (cfg_i.chan_sel > 5'd16) ? 4'd15 : 4'(cfg_i.chan_sel - 5'd1);
  assign sel_ok   = (cfg_i.chan_sel == 5'd0) || (want == ch);
  assign is_note  = msg_i.three && sel_ok && (kind == KIND_NOTE_ON || kind == KIND_NOTE_OFF);
  assign is_on    = (kind == KIND_NOTE_ON) && (vel != 7'd0);
  assign in_range = (key >= cfg_i.trig_low) && (key <= cfg_i.trig_high);

  always_comb begin
    case (cfg_i.rel_mode)
      REL_ZERO:  rel = 7'd0;
      REL_CHOKE: rel = stored_i;
      default:   rel = vel;
    endcase
  end

  always_comb begin
    dec_o.emit_off          = 1'b0;
    dec_o.emit_orig         = 1'b1;
    dec_o.wr_en             = 1'b0;
    dec_o.wr_vel            = 7'd0;
    dec_o.off_msg.status    = {KIND_NOTE_OFF, ch};
    dec_o.off_msg.data_one  = {1'b0, cfg_i.choke};
    dec_o.off_msg.data_two  = {1'b0, rel};
    dec_o.off_msg.three     = 1'b1;
    dec_o.off_msg.stamp     = msg_i.stamp;
    if (is_note) begin
      if (is_on) begin
        if (key == cfg_i.choke) begin
          dec_o.wr_en  = 1'b1;
          dec_o.wr_vel = vel;
        end else if (in_range && stored_i != 7'd0) begin
          dec_o.emit_off = 1'b1;
          dec_o.wr_en    = 1'b1;
        end
      end else if (key == cfg_i.choke) begin
        if (stored_i == 7'd0) begin
          dec_o.emit_orig = 1'b0;
        end else begin
          dec_o.wr_en = 1'b1;
        end
      end
    end
  end

endmodule

/* sv/midi_choke_filter_top.sv */
// midi_choke_filter_top: choke filter for short midi messages
// depends on mcf_pkg and mcf_decide
//
//   channel | handshake                   | word
//   --------+-----------------------------+-------------------------------------------
//   in      | in_valid_i / in_stall_o     | status, data one, data two, three, time
//   out     | out_valid_o / out_stall_i   | status, data one, data two, three, time, last
//   cfg     | cfg_valid_i / cfg_ready_o   | register index, write data
//
// input to output passes the input register, the decision and the output register
// one message per cycle if one word each and no stall; a choke note-off adds a word
// velocity store is per-channel flops, read and updated in the decision cycle
// reset clears valids and velocity store, loads cfg reset values; cfg_ready_o is always high
// output stall holds the output register, then the input register, then in_stall_o
module midi_choke_filter_top import mcf_pkg::*; #(
  parameter int CHANNELS = DefChannels
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          status_byte_i,
  input  logic [7:0]          data_one_i,
  input  logic [7:0]          data_two_i,
  input  logic                three_bytes_i,
  input  logic [31:0]         timestamp_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_status_o,
  output logic [7:0]          out_data_one_o,
  output logic [7:0]          out_data_two_o,
  output logic                out_three_bytes_o,
  output logic [31:0]         out_time_o,
  output logic                last_result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [4:0] ChanLim = 5'(CHANNELS);

  cfg_t cfg_q, cfg_d;

  logic       iv_q, iv_d;
  msg_t       in_q, in_d;
  logic       ov_q, ov_d;
  msg_t       out_q, out_d;
  logic       last_q, last_d;
  logic       pv_q, pv_d;
  msg_t       pend_q, pend_d;

  logic [6:0] vel_q [CHANNELS];

  logic            in_take;
  logic            out_pop;
  logic            out_free;
  logic            adv;
  logic            ch_ok;
  logic [IdxW-1:0] idx;
  logic [6:0]      stored;
  dec_t            dec;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_CHAN_SEL:  cfg_d.chan_sel  = cfg_data_i[4:0];
        REG_TRIG_LOW:  cfg_d.trig_low  = cfg_data_i[6:0];
        REG_TRIG_HIGH: cfg_d.trig_high = cfg_data_i[6:0];
        REG_CHOKE:     cfg_d.choke     = cfg_data_i[6:0];
        REG_REL_MODE:  cfg_d.rel_mode  = cfg_data_i[1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  assign ch_ok  = {1'b0, in_q.status[3:0]} < ChanLim;
  assign idx    = in_q.status[IdxW-1:0];
  assign stored = ch_ok ? vel_q[idx] : 7'd0;

  mcf_decide u_decide (
    .msg_i    (in_q),
    .cfg_i    (cfg_q),
    .stored_i (stored),
    .dec_o    (dec)
  );

  assign out_pop    = ov_q && !out_stall_i;
  assign out_free   = !ov_q || (out_pop && !pv_q);
  assign adv        = iv_q && out_free;
  assign in_stall_o = iv_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    iv_d = iv_q;
    in_d = in_q;
    if (in_take) begin
      iv_d           = 1'b1;
      in_d.status    = status_byte_i;
      in_d.data_one  = data_one_i;
      in_d.data_two  = data_two_i;
      in_d.three     = three_bytes_i;
      in_d.stamp     = timestamp_i;
    end else if (adv) begin
      iv_d = 1'b0;
    end
  end

  always_comb begin
    ov_d   = ov_q;
    out_d  = out_q;
    last_d = last_q;
    pv_d   = pv_q;
    pend_d = pend_q;
    if (out_pop) begin
      if (pv_q) begin
        out_d  = pend_q;
        last_d = 1'b1;
        pv_d   = 1'b0;
      end else begin
        ov_d = 1'b0;
      end
    end
    if (adv) begin
      if (dec.emit_off) begin
        ov_d   = 1'b1;
        out_d  = dec.off_msg;
        last_d = 1'b0;
        pv_d   = 1'b1;
        pend_d = in_q;
      end else if (dec.emit_orig) begin
        ov_d   = 1'b1;
        out_d  = in_q;
        last_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.chan_sel  <= RstChanSel;
      cfg_q.trig_low  <= RstTrigLow;
      cfg_q.trig_high <= RstTrigHigh;
      cfg_q.choke     <= RstChoke;
      cfg_q.rel_mode  <= RstRelMode;
      iv_q            <= 1'b0;
      ov_q            <= 1'b0;
      pv_q            <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      iv_q  <= iv_d;
      ov_q  <= ov_d;
      pv_q  <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q   <= in_d;
    out_q  <= out_d;
    last_q <= last_d;
    pend_q <= pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        vel_q[i] <= 7'd0;
      end
    end else if (adv && dec.wr_en && ch_ok) begin
      vel_q[idx] <= dec.wr_vel;
    end
  end

  assign out_valid_o       = ov_q;
  assign out_status_o      = out_q.status;
  assign out_data_one_o    = out_q.data_one;
  assign out_data_two_o    = out_q.data_two;
  assign out_three_bytes_o = out_q.three;
  assign out_time_o        = out_q.stamp;
  assign last_result_o     = last_q;

endmodule

/* sv/mcf_checker.sv */
// mcf_checker: port-level checks for midi_choke_filter_top, bound to the top level
// depends on mcf_pkg and midi_choke_filter_top
module mcf_checker import mcf_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [7:0]          out_status_o,
  input logic [7:0]          out_data_one_o,
  input logic [7:0]          out_data_two_o,
  input logic                out_three_bytes_o,
  input logic [31:0]         out_time_o,
  input logic                last_result_o
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_status_o)
      && $stable(out_data_one_o) && $stable(out_data_two_o) && $stable(out_time_o)
      && $stable(last_result_o))
    else $error("stalled output word changed");

  // inserted word is a three byte note-off
  a_off_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_result_o |-> out_status_o[7:4] == KIND_NOTE_OFF
      && out_three_bytes_o)
    else $error("non-last word is not a note-off");

  // inserted note-off is followed at once by its original message
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_result_o |=> out_valid_o && last_result_o
      && out_time_o == $past(out_time_o))
    else $error("note-off not followed by its message");

  // long messages pass as a single word
  a_long_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_three_bytes_o |-> last_result_o)
    else $error("long message not last word");

endmodule

bind midi_choke_filter_top mcf_checker u_mcf_checker (.*);

/* tb/tb.sv */
// tb: self-checking testbench for midi_choke_filter_top, per-channel choke velocity
// kept in a local predictor; directed, register-sweep, backpressure and random tests
// depends on mcf_pkg and midi_choke_filter_top
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mcf_pkg::*;

  localparam int CHANNELS     = DefChannels;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 8;
  localparam int IDLE_LIMIT   = 5000;
  localparam int REG_SETTINGS = 16;
  localparam int RANDOM_ITEMS = 140;

  localparam logic [1:0] REL_TRIGGER  = 2'd2;
  localparam logic [1:0] REL_SPARE    = 2'd3;
  localparam logic [3:0] KIND_CONTROL = 4'hb;
  localparam logic [7:0] STATUS_SYSEX = 8'hf0;

  typedef struct packed {
    msg_t word;
    logic last;
  } out_word_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [7:0]          status_byte_i;
  logic [7:0]          data_one_i;
  logic [7:0]          data_two_i;
  logic                three_bytes_i;
  logic [31:0]         timestamp_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [7:0]          out_status_o;
  logic [7:0]          out_data_one_o;
  logic [7:0]          out_data_two_o;
  logic                out_three_bytes_o;
  logic [31:0]         out_time_o;
  logic                last_result_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  out_word_t  pending_words[$];
  logic [6:0] chan_vel[CHANNELS];
  cfg_t       model_cfg;

  bit hold_request   = 1'b0;
  bit sender_calm    = 1'b0;
  bit receiver_calm  = 1'b0;
  int mismatches     = 0;
  int items_sent     = 0;
  int words_checked  = 0;
  int reg_writes     = 0;

  midi_choke_filter_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .status_byte_i    (status_byte_i),
    .data_one_i       (data_one_i),
    .data_two_i       (data_two_i),
    .three_bytes_i    (three_bytes_i),
    .timestamp_i      (timestamp_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_status_o     (out_status_o),
    .out_data_one_o   (out_data_one_o),
    .out_data_two_o   (out_data_two_o),
    .out_three_bytes_o(out_three_bytes_o),
    .out_time_o       (out_time_o),
    .last_result_o    (last_result_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [3:0] selected_chan(logic [4:0] sel);
    if (sel > 5'd16) begin
      return 4'd15;
    end
    return sel[3:0] - 4'd1;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic msg_t mk(logic [7:0] st, logic [7:0] d1, logic [7:0] d2, logic three,
                              logic [31:0] stamp);
    msg_t m;
    m.status   = st;
    m.data_one = d1;
    m.data_two = d2;
    m.three    = three;
    m.stamp    = stamp;
    return m;
  endfunction

  // works out the words one accepted message produces and updates the velocity store
  function automatic void choke_predict(msg_t m);
    logic [3:0] ch;
    logic [3:0] kind;
    logic [6:0] key;
    logic [6:0] vel;
    logic [6:0] rel;
    logic       drop;
    msg_t       off;
    ch   = m.status[3:0];
    kind = m.status[7:4];
    key  = m.data_one[6:0];
    vel  = m.data_two[6:0];
    drop = 1'b0;
    if (!m.three || (model_cfg.chan_sel != 5'd0 && selected_chan(model_cfg.chan_sel) != ch) ||
        (kind != KIND_NOTE_ON && kind != KIND_NOTE_OFF)) begin
      pending_words.push_back('{m, 1'b1});
      return;
    end
    if (kind == KIND_NOTE_ON && vel != 7'd0) begin
      if (key == model_cfg.choke) begin
        chan_vel[ch] = vel;
      end else if (key >= model_cfg.trig_low && key <= model_cfg.trig_high &&
                   chan_vel[ch] != 7'd0) begin
        case (model_cfg.rel_mode)
          REL_ZERO:  rel = 7'd0;
          REL_CHOKE: rel = chan_vel[ch];
          default:   rel = vel;
        endcase
        off = mk({KIND_NOTE_OFF, ch}, {1'b0, model_cfg.choke}, {1'b0, rel}, 1'b1, m.stamp);
        pending_words.push_back('{off, 1'b0});
        chan_vel[ch] = 7'd0;
      end
    end else if (key == model_cfg.choke) begin
      if (chan_vel[ch] == 7'd0) begin
        drop = 1'b1;
      end else begin
        chan_vel[ch] = 7'd0;
      end
    end
    if (!drop) begin
      pending_words.push_back('{m, 1'b1});
    end
  endfunction

  // mostly note traffic aimed at the choke note and trigger range, some noise
  function automatic msg_t make_msg();
    msg_t       m;
    int         pick;
    logic [3:0] ch;
    logic [6:0] key;
    logic [6:0] vel;
    pick       = $urandom_range(0, 99);
    m.status   = 8'($urandom);
    m.data_one = 8'($urandom);
    m.data_two = 8'($urandom);
    m.three    = 1'b1;
    m.stamp    = $urandom;
    if (pick < 80) begin
      if (model_cfg.chan_sel != 5'd0 && $urandom_range(0, 99) < 85) begin
        ch = selected_chan(model_cfg.chan_sel);
      end else if ($urandom_range(0, 3) != 0) begin
        ch = 4'($urandom_range(0, 3));
      end else begin
        ch = 4'($urandom_range(0, 15));
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        key = model_cfg.choke;
      end else if (pick < 80 && model_cfg.trig_low <= model_cfg.trig_high) begin
        key = 7'($urandom_range(model_cfg.trig_low, model_cfg.trig_high));
      end else begin
        key = 7'($urandom_range(0, 127));
      end
      vel = ($urandom_range(0, 99) < 15) ? 7'd0 : 7'($urandom_range(1, 127));
      m.status   = {($urandom_range(0, 99) < 60) ? KIND_NOTE_ON : KIND_NOTE_OFF, ch};
      m.data_one = {($urandom_range(0, 4) == 0), key};
      m.data_two = {($urandom_range(0, 4) == 0), vel};
    end else if (pick < 90) begin
      m.three = 1'b0;
    end
    return m;
  endfunction

  function automatic cfg_t pick_setting(int phase);
    cfg_t c;
    int   r;
    case (phase)
      0: c = '{5'd0, 7'd0, 7'd127, 7'd0, REL_ZERO};
      1: c = '{5'd1, 7'd127, 7'd127, 7'd127, REL_CHOKE};
      2: c = '{5'd16, 7'd60, 7'd72, 7'd127, REL_TRIGGER};
      3: begin
        c = '{5'd17, 7'd80, 7'd20, 7'd0, REL_SPARE};
        c.chan_sel = 5'($urandom_range(17, 31));
      end
      4: c = '{RstChanSel, RstTrigLow, RstTrigHigh, RstChoke, RstRelMode};
      default: begin
        r = $urandom_range(0, 99);
        if (r < 30) begin
          c.chan_sel = 5'd0;
        end else if (r < 90) begin
          c.chan_sel = 5'($urandom_range(1, 16));
        end else begin
          c.chan_sel = 5'($urandom_range(17, 31));
        end
        c.trig_low  = 7'($urandom_range(0, 127));
        c.trig_high = (int'(c.trig_low) + 20 > 127) ? 7'd127 :
                      7'(c.trig_low + 7'($urandom_range(0, 20)));
        if ($urandom_range(0, 99) < 15) begin
          c.trig_high = 7'($urandom_range(0, 127));
        end
        if ($urandom_range(0, 99) < 30 && c.trig_low <= c.trig_high) begin
          c.choke = 7'($urandom_range(c.trig_low, c.trig_high));
        end else begin
          c.choke = 7'($urandom_range(0, 127));
        end
        c.rel_mode = 2'($urandom_range(0, 3));
      end
    endcase
    return c;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : check_words
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_checked++;
      if (pending_words.size() == 0) begin
        $error("output word with nothing pending: status %0h time %0h", out_status_o,
               out_time_o);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        check_field("out_status", 32'(want.word.status), 32'(out_status_o));
        check_field("out_data_one", 32'(want.word.data_one), 32'(out_data_one_o));
        check_field("out_data_two", 32'(want.word.data_two), 32'(out_data_two_o));
        check_field("out_three_bytes", 32'(want.word.three), 32'(out_three_bytes_o));
        check_field("out_time", want.word.stamp, out_time_o);
        check_field("last_result", 32'(want.last), 32'(last_result_o));
      end
    end
  end

  initial begin : receiver
    int stall_left;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
        out_stall_i <= 1'b0;
      end else if (receiver_calm) begin
        out_stall_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = gap_len();
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
    $display("midi_choke_filter_top verification failed");
    $finish;
  end

  task automatic send_msg(msg_t m);
    in_valid_i    <= 1'b1;
    status_byte_i <= m.status;
    data_one_i    <= m.data_one;
    data_two_i    <= m.data_two;
    three_bytes_i <= m.three;
    timestamp_i   <= m.stamp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    choke_predict(m);
    items_sent++;
  endtask

  task automatic offer(msg_t m);
    int n;
    send_msg(m);
    n = sender_calm ? 0 : gap_len();
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic run_traffic(int count);
    repeat (count) offer(make_msg());
  endtask

  // lets dropped note-offs clear the pipeline before registers change
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_CHAN_SEL:  model_cfg.chan_sel  = val[4:0];
      REG_TRIG_LOW:  model_cfg.trig_low  = val[6:0];
      REG_TRIG_HIGH: model_cfg.trig_high = val[6:0];
      REG_CHOKE:     model_cfg.choke     = val[6:0];
      REG_REL_MODE:  model_cfg.rel_mode  = val[1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic program_regs(cfg_t c);
    logic [7:0] pad;
    pad = 8'($urandom);
    write_reg(REG_CHAN_SEL, {pad[7:5], c.chan_sel});
    write_reg(REG_TRIG_LOW, {pad[4], c.trig_low});
    write_reg(REG_TRIG_HIGH, {pad[3], c.trig_high});
    write_reg(REG_CHOKE, {pad[2], c.choke});
    write_reg(REG_REL_MODE, {pad[5:0], c.rel_mode});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_directed();
    logic [7:0] on0, on1, on2, on3, on14, on15;
    logic [7:0] off0, off2, off3, off15;
    on0   = {KIND_NOTE_ON, 4'd0};
    on1   = {KIND_NOTE_ON, 4'd1};
    on2   = {KIND_NOTE_ON, 4'd2};
    on3   = {KIND_NOTE_ON, 4'd3};
    on14  = {KIND_NOTE_ON, 4'd14};
    on15  = {KIND_NOTE_ON, 4'd15};
    off0  = {KIND_NOTE_OFF, 4'd0};
    off2  = {KIND_NOTE_OFF, 4'd2};
    off3  = {KIND_NOTE_OFF, 4'd3};
    off15 = {KIND_NOTE_OFF, 4'd15};
    // store, trigger, then a choke note-off with nothing stored
    offer(mk(on0, 8'd46, 8'd100, 1'b1, $urandom));
    offer(mk(on0, 8'd42, 8'd64, 1'b1, $urandom));
    offer(mk(off0, 8'd46, 8'd0, 1'b1, $urandom));
    // zero-velocity note-on acts as note-off, high bits ignored
    offer(mk(on1, 8'd46, 8'd127, 1'b1, $urandom));
    offer(mk(on1, 8'd42, 8'd0, 1'b1, $urandom));
    offer(mk(on1, 8'd46, 8'h80, 1'b1, $urandom));
    offer(mk(on1, 8'd46, 8'h80, 1'b1, $urandom));
    offer(mk(on15, 8'hae, 8'h85, 1'b1, $urandom));
    offer(mk(on14, 8'd42, 8'd90, 1'b1, $urandom));
    offer(mk(on15, 8'haa, 8'hff, 1'b1, $urandom));
    offer(mk(on15, 8'd42, 8'd10, 1'b1, $urandom));
    offer(mk(off15, 8'd46, 8'd127, 1'b1, $urandom));
    offer(mk(on2, 8'd46, 8'd33, 1'b1, $urandom));
    offer(mk(off2, 8'd46, 8'd33, 1'b1, $urandom));
    // other kinds, short and long messages
    offer(mk({KIND_CONTROL, 4'd0}, 8'd46, 8'd100, 1'b1, $urandom));
    offer(mk(on0, 8'd46, 8'd1, 1'b0, $urandom));
    offer(mk(on0, 8'd42, 8'd1, 1'b1, $urandom));
    offer(mk(STATUS_SYSEX, 8'h7e, 8'h01, 1'b0, $urandom));
    offer(mk(8'h00, 8'h00, 8'h00, 1'b1, 32'h0));
    offer(mk(8'hff, 8'hff, 8'hff, 1'b1, 32'hffff_ffff));
    offer(mk(8'hff, 8'hff, 8'hff, 1'b0, 32'h0));
    offer(mk(on3, 8'd46, 8'd127, 1'b1, $urandom));
    offer(mk(on3, 8'd43, 8'd50, 1'b1, $urandom));
    offer(mk(off3, 8'd42, 8'd0, 1'b1, $urandom));
  endtask

  task automatic test_register_extremes();
    for (int p = 0; p < 5; p++) begin
      settle();
      program_regs(pick_setting(p));
      if (p == 0) begin
        for (int i = REG_REL_MODE + 1; i < 2 ** CfgIdxW; i++) begin
          write_reg(CfgIdxW'(i), CfgDataW'($urandom));
        end
        cfg_valid_i <= 1'b0;
      end
      run_traffic(40);
    end
  endtask

  task automatic test_backpressure();
    settle();
    sender_calm   = 1'b1;
    receiver_calm = 1'b0;
    hold_request  = 1'b1;
    run_traffic(60);
    sender_calm = 1'b0;
  endtask

  task automatic test_random_traffic();
    for (int p = 5; p < REG_SETTINGS; p++) begin
      settle();
      program_regs(pick_setting(p));
      sender_calm   = (p % 3 == 0);
      receiver_calm = (p % 4 == 0);
      run_traffic(RANDOM_ITEMS);
    end
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    status_byte_i = '0;
    data_one_i    = '0;
    data_two_i    = '0;
    three_bytes_i = 1'b0;
    timestamp_i   = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    model_cfg     = '{RstChanSel, RstTrigLow, RstTrigHigh, RstChoke, RstRelMode};
    for (int i = 0; i < CHANNELS; i++) begin
      chan_vel[i] = 7'd0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();
    settle();
    if (pending_words.size() != 0) begin
      $error("%0d expected words never arrived", pending_words.size());
      mismatches++;
    end
    $display("covered %0d messages and %0d output words across %0d register settings",
             items_sent, words_checked, REG_SETTINGS);
    $display("%0d register writes, one long output hold, %0d mismatches", reg_writes,
             mismatches);
    if (mismatches == 0) begin
      $display("midi_choke_filter_top verification clean");
    end else begin
      $display("midi_choke_filter_top verification failed");
    end
    $finish;
  end

endmodule
